/* rtl/rfdm_pkg.sv */
// Package for the remote frame drive mixer: shared types and constants.
// Used by rfdm_mix and remote_frame_drive_mixer_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rfdm_pkg;

  // Link frame header byte.
  localparam logic [7:0] FRAME_HEADER = 8'hAA;

  // Bit positions inside the button byte.
  localparam int BTN_UP     = 7;
  localparam int BTN_DOWN   = 6;
  localparam int BTN_LEFT   = 5;
  localparam int BTN_RIGHT  = 4;
  localparam int BTN_CROSS  = 2;
  localparam int BTN_SQUARE = 1;
  localparam int BTN_CIRCLE = 0;

  // Item kinds on the input and result streams.
  localparam logic KIND_FRAME     = 1'b0;
  localparam logic KIND_EMERGENCY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_POWER  = 2'd0;
  localparam logic [1:0] REG_DRIVE_STEP = 2'd1;
  localparam logic [1:0] REG_LIFT_DUTY  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] MAX_POWER_RST  = 8'd250;
  localparam logic [6:0] DRIVE_STEP_RST = 7'd5;
  localparam logic [7:0] LIFT_DUTY_RST  = 8'd200;

  // Stored wheel power, and the wider working value used before clamping.
  typedef logic signed [9:0]  power_t;
  typedef logic signed [10:0] power_wide_t;

  // Frame parser phases.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_BUTTONS = 4'b0010,
    PH_LEFT_TR = 4'b0100,
    PH_RIGHT_TR = 4'b1000
  } phase_t;

endpackage

`default_nettype wire

/* rtl/rfdm_mix.sv */
// Wheel power mixer: applies one frame's direction buttons to the wheel powers.
// Depends on rfdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfdm_mix (
  input  wire logic [7:0]      buttons,
  input  wire rfdm_pkg::power_t right_power,
  input  wire rfdm_pkg::power_t left_power,
  input  wire logic [6:0]      drive_step,
  input  wire logic [7:0]      max_power,
  output rfdm_pkg::power_t     right_power_next,
  output rfdm_pkg::power_t     left_power_next
);

  function automatic logic same_sign(input rfdm_pkg::power_wide_t a,
                                     input rfdm_pkg::power_wide_t b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  rfdm_pkg::power_wide_t r;
  rfdm_pkg::power_wide_t l;
  rfdm_pkg::power_wide_t s;
  rfdm_pkg::power_wide_t lim;

  // Buttons are applied in a fixed order: up, down, right, left, cross.
  // The range stays within eleven signed bits before the clamp.
  always_comb begin
    s   = rfdm_pkg::power_wide_t'({4'b0, drive_step});
    lim = rfdm_pkg::power_wide_t'({3'b0, max_power});
    r   = rfdm_pkg::power_wide_t'(right_power);
    l   = rfdm_pkg::power_wide_t'(left_power);
    if (buttons[rfdm_pkg::BTN_UP]) begin
      r = r + s;
      l = l + s;
    end
    if (buttons[rfdm_pkg::BTN_DOWN]) begin
      r = r - s;
      l = l - s;
    end
    // Turns are differential when both wheels run the same way, else a pivot.
    if (buttons[rfdm_pkg::BTN_RIGHT]) begin
      if (same_sign(r, l)) begin
        r = r - s;
        l = l + s;
      end else if (r < 0) begin
        l = '0;
        r = r - s;
      end else begin
        r = '0;
        l = l + s;
      end
    end
    if (buttons[rfdm_pkg::BTN_LEFT]) begin
      if (same_sign(r, l)) begin
        r = r + s;
        l = l - s;
      end else if (l < 0) begin
        r = '0;
        l = l - s;
      end else begin
        l = '0;
        r = r + s;
      end
    end
    if (buttons[rfdm_pkg::BTN_CROSS]) begin
      r = '0;
      l = '0;
    end
    // Clamp both powers to the configured magnitude.
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    if (l > lim) begin
      l = lim;
    end else if (l < -lim) begin
      l = -lim;
    end
  end

  assign right_power_next = r[9:0];
  assign left_power_next  = l[9:0];

endmodule

`default_nettype wire

/* rtl/remote_frame_drive_mixer_unit.sv */
// Remote frame drive mixer top level: parses link frames and drives wheel, blade,
// lift and stepper outputs. Depends on rfdm_pkg and rfdm_mix.
// m_axis_tvalid rises from the result register, loaded from the input register.
// Throughput: one item per cycle; an item that closes a frame or is an emergency
// waits in the input register only while the result register holds an unread result.
// Reset (rst, synchronous) empties both registers, returns the parser to header
// hunting, zeroes powers and held frame bytes, and reloads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module remote_frame_drive_mixer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input item stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser,   // [0] req_type
  // Result item stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] right_duty, [8] right_reverse, [16:9] left_duty, [17] left_reverse,
  // [25:18] blade_duty, [33:26] lift_raise_duty, [41:34] lift_lower_duty,
  // [42] stepper_enable, [47:43] zero
  output logic [47:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // [0] result_kind
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // Configuration registers.
  logic [7:0] max_power;
  logic [6:0] drive_step;
  logic [7:0] lift_duty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_power  <= rfdm_pkg::MAX_POWER_RST;
      drive_step <= rfdm_pkg::DRIVE_STEP_RST;
      lift_duty  <= rfdm_pkg::LIFT_DUTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfdm_pkg::REG_MAX_POWER:  max_power  <= cfg_data;
        rfdm_pkg::REG_DRIVE_STEP: drive_step <= cfg_data[6:0];
        rfdm_pkg::REG_LIFT_DUTY:  lift_duty  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;

  // Parser and drive state.
  rfdm_pkg::phase_t phase;
  logic [7:0]       held_buttons;
  logic [7:0]       held_left_trigger;
  rfdm_pkg::power_t right_power;
  rfdm_pkg::power_t left_power;
  logic             right_dir_last;
  logic             left_dir_last;

  // Result register.
  logic        out_valid;
  logic        out_kind;
  logic [47:0] out_data;

  rfdm_pkg::power_t right_power_next;
  rfdm_pkg::power_t left_power_next;

  logic out_free;
  logic in_emits;
  logic in_advance;

  rfdm_mix u_mix (
    .buttons          (held_buttons),
    .right_power      (right_power),
    .left_power       (left_power),
    .drive_step       (drive_step),
    .max_power        (max_power),
    .right_power_next (right_power_next),
    .left_power_next  (left_power_next)
  );

  // The held item moves on when it makes no result or the result slot is free.
  assign out_free   = !out_valid || m_axis_tready;
  assign in_emits   = (in_kind == rfdm_pkg::KIND_EMERGENCY) || (phase == rfdm_pkg::PH_RIGHT_TR);
  assign in_advance = in_valid && (!in_emits || out_free);

  assign s_axis_tready = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  // Derived result fields for a completed frame.
  logic       right_rev_next;
  logic       left_rev_next;
  logic [7:0] right_mag;
  logic [7:0] left_mag;
  logic [7:0] raise_duty;
  logic [7:0] lower_duty;
  logic       stepper_en;

  always_comb begin
    right_rev_next = !(right_power_next > 0);
    left_rev_next  = !(left_power_next > 0);
    right_mag = right_power_next[9] ? 8'(-right_power_next) : right_power_next[7:0];
    left_mag  = left_power_next[9] ? 8'(-left_power_next) : left_power_next[7:0];
    raise_duty = '0;
    lower_duty = '0;
    // Circle wins over square.
    if (held_buttons[rfdm_pkg::BTN_CIRCLE]) begin
      raise_duty = lift_duty;
    end else if (held_buttons[rfdm_pkg::BTN_SQUARE]) begin
      lower_duty = lift_duty;
    end
    stepper_en = (held_left_trigger != 8'd0);
  end

  // Parser and state update for the item leaving the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= rfdm_pkg::PH_HUNT;
      held_buttons      <= '0;
      held_left_trigger <= '0;
      right_power       <= '0;
      left_power        <= '0;
      right_dir_last    <= 1'b0;
      left_dir_last     <= 1'b0;
    end else if (in_advance) begin
      if (in_kind == rfdm_pkg::KIND_EMERGENCY) begin
        phase             <= rfdm_pkg::PH_HUNT;
        held_buttons      <= '0;
        held_left_trigger <= '0;
        right_power       <= '0;
        left_power        <= '0;
      end else begin
        unique case (phase)
          rfdm_pkg::PH_HUNT: begin
            if (in_byte == rfdm_pkg::FRAME_HEADER) begin
              phase <= rfdm_pkg::PH_BUTTONS;
            end
          end
          rfdm_pkg::PH_BUTTONS: begin
            held_buttons <= in_byte;
            phase        <= rfdm_pkg::PH_LEFT_TR;
          end
          rfdm_pkg::PH_LEFT_TR: begin
            held_left_trigger <= in_byte;
            phase             <= rfdm_pkg::PH_RIGHT_TR;
          end
          rfdm_pkg::PH_RIGHT_TR: begin
            right_power    <= right_power_next;
            left_power     <= left_power_next;
            right_dir_last <= right_rev_next;
            left_dir_last  <= left_rev_next;
            phase          <= rfdm_pkg::PH_HUNT;
          end
          default: begin
            phase <= rfdm_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // Result register with its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance && in_emits) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_emits) begin
      out_kind <= in_kind;
      if (in_kind == rfdm_pkg::KIND_EMERGENCY) begin
        // All drives off; direction pins keep their last driven level.
        out_data <= {5'b0, 1'b0, 8'd0, 8'd0, 8'd0, left_dir_last, 8'd0,
                     right_dir_last, 8'd0};
      end else begin
        out_data <= {5'b0, stepper_en, lower_duty, raise_duty, in_byte,
                     left_rev_next, left_mag, right_rev_next, right_mag};
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Testbench for remote_frame_drive_mixer_unit: streams link bytes and emergency items,
// predicts every drive result with its own mixer model and checks the result stream.
// Depends on rfdm_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 1ps

module testbench;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 4;
  localparam int PHASE_ITEMS   = 206;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 100;
  localparam int LIMIT_NS      = 7_200_000;

  // One drive result, field by field.
  typedef struct packed {
    logic       kind;
    logic [7:0] right_duty;
    logic       right_rev;
    logic [7:0] left_duty;
    logic       left_rev;
    logic [7:0] blade;
    logic [7:0] raise_duty;
    logic [7:0] lower_duty;
    logic       stepper_en;
  } drive_t;

  // One row of the directed link sequence.
  typedef struct {
    logic       req;
    logic [7:0] data;
    bit         typed;
    drive_t     want;
  } link_row_t;

  localparam drive_t NO_DRIVE = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // Mixer model: configuration, parser and wheel state.
  logic [7:0]        lim_q  = rfdm_pkg::MAX_POWER_RST;
  logic [6:0]        step_q = rfdm_pkg::DRIVE_STEP_RST;
  logic [7:0]        lift_q = rfdm_pkg::LIFT_DUTY_RST;
  rfdm_pkg::phase_t  link_ph = rfdm_pkg::PH_HUNT;
  logic [7:0]        held_btn = '0;
  logic [7:0]        held_ltrig = '0;
  rfdm_pkg::power_t  right_pw = '0;
  rfdm_pkg::power_t  left_pw = '0;
  logic              right_dir = 1'b0;
  logic              left_dir = 1'b0;

  drive_t     pending_drives[$];
  link_row_t  link_rows[$];
  int         mismatches = 0;
  bit         calm = 1'b0;
  bit         burst = 1'b0;
  bit         hold_long = 1'b0;

  remote_frame_drive_mixer_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic drive_t make_drive(logic k, logic [7:0] rd, logic rr, logic [7:0] ld,
                                        logic lr, logic [7:0] bl, logic [7:0] ra,
                                        logic [7:0] lo, logic st);
    drive_t d;
    d.kind = k;
    d.right_duty = rd;
    d.right_rev = rr;
    d.left_duty = ld;
    d.left_rev = lr;
    d.blade = bl;
    d.raise_duty = ra;
    d.lower_duty = lo;
    d.stepper_en = st;
    return d;
  endfunction

  function automatic int clamp_pw(int p, int lim);
    if (p > lim) return lim;
    if (p < -lim) return -lim;
    return p;
  endfunction

  function automatic bit same_sign(int a, int b);
    return ((a > 0) && (b > 0)) || ((a < 0) && (b < 0));
  endfunction

  // Advances the mixer model by one link item; returns 1 when a drive result follows.
  function automatic bit mix_link_item(input logic req, input logic [7:0] data,
                                       output drive_t res);
    int s;
    int r;
    int l;
    int rmag;
    int lmag;
    logic [7:0] up_duty;
    logic [7:0] dn_duty;
    res = NO_DRIVE;
    // An emergency clears powers and the parser but keeps the last direction pins.
    if (req == rfdm_pkg::KIND_EMERGENCY) begin
      right_pw = '0;
      left_pw = '0;
      held_btn = '0;
      held_ltrig = '0;
      link_ph = rfdm_pkg::PH_HUNT;
      res = make_drive(rfdm_pkg::KIND_EMERGENCY, 8'd0, right_dir, 8'd0, left_dir, 8'd0,
                       8'd0, 8'd0, 1'b0);
      return 1'b1;
    end
    // Frame parser; a header byte inside the body is taken as body.
    case (link_ph)
      rfdm_pkg::PH_HUNT: begin
        if (data == rfdm_pkg::FRAME_HEADER) link_ph = rfdm_pkg::PH_BUTTONS;
        return 1'b0;
      end
      rfdm_pkg::PH_BUTTONS: begin
        held_btn = data;
        link_ph = rfdm_pkg::PH_LEFT_TR;
        return 1'b0;
      end
      rfdm_pkg::PH_LEFT_TR: begin
        held_ltrig = data;
        link_ph = rfdm_pkg::PH_RIGHT_TR;
        return 1'b0;
      end
      default: link_ph = rfdm_pkg::PH_HUNT;
    endcase
    // Wheel mixing at full width, clamped at the end.
    s = int'(step_q);
    r = int'(right_pw);
    l = int'(left_pw);
    if (held_btn[rfdm_pkg::BTN_UP]) begin
      r += s;
      l += s;
    end
    if (held_btn[rfdm_pkg::BTN_DOWN]) begin
      r -= s;
      l -= s;
    end
    if (held_btn[rfdm_pkg::BTN_RIGHT]) begin
      if (same_sign(r, l)) begin
        r -= s;
        l += s;
      end else if (r < 0) begin
        l = 0;
        r -= s;
      end else begin
        r = 0;
        l += s;
      end
    end
    if (held_btn[rfdm_pkg::BTN_LEFT]) begin
      if (same_sign(r, l)) begin
        r += s;
        l -= s;
      end else if (l < 0) begin
        r = 0;
        l -= s;
      end else begin
        l = 0;
        r += s;
      end
    end
    if (held_btn[rfdm_pkg::BTN_CROSS]) begin
      r = 0;
      l = 0;
    end
    r = clamp_pw(r, int'(lim_q));
    l = clamp_pw(l, int'(lim_q));
    right_pw = rfdm_pkg::power_t'(r);
    left_pw = rfdm_pkg::power_t'(l);
    right_dir = (r > 0) ? 1'b0 : 1'b1;
    left_dir = (l > 0) ? 1'b0 : 1'b1;
    rmag = (r < 0) ? -r : r;
    lmag = (l < 0) ? -l : l;
    // Circle wins over square on the lift.
    up_duty = held_btn[rfdm_pkg::BTN_CIRCLE] ? lift_q : 8'd0;
    dn_duty = (!held_btn[rfdm_pkg::BTN_CIRCLE] && held_btn[rfdm_pkg::BTN_SQUARE]) ?
              lift_q : 8'd0;
    link_ph = rfdm_pkg::PH_HUNT;
    res = make_drive(rfdm_pkg::KIND_FRAME, rmag[7:0], right_dir, lmag[7:0], left_dir, data,
                     up_duty, dn_duty, held_ltrig != 8'd0);
    return 1'b1;
  endfunction

  // Idle length shared by both sides: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 70) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_row(logic req, logic [7:0] data, bit typed, drive_t want);
    link_row_t row;
    row.req = req;
    row.data = data;
    row.typed = typed;
    row.want = want;
    link_rows.push_back(row);
  endtask

  // Offers one link item, waits for acceptance and records the expected drive.
  task automatic send_link(logic req, logic [7:0] data, bit typed, drive_t want);
    drive_t res;
    bit hit;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    hit = mix_link_item(req, data, res);
    if (typed) pending_drives.push_back(want);
    else if (hit) pending_drives.push_back(res);
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rfdm_pkg::REG_MAX_POWER:  lim_q = val;
      rfdm_pkg::REG_DRIVE_STEP: step_q = val[6:0];
      rfdm_pkg::REG_LIFT_DUTY:  lift_q = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] lim, logic [7:0] step, logic [7:0] lift);
    write_reg(rfdm_pkg::REG_MAX_POWER, lim);
    write_reg(rfdm_pkg::REG_DRIVE_STEP, step);
    write_reg(rfdm_pkg::REG_LIFT_DUTY, lift);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering items until every expected drive has come, then lets the pipe settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int n;
    bit held_once;
    forever begin
      @(posedge clk);
      if (hold_long && !held_once) begin
        held_once = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        n = idle_len();
        if (n > 0) begin
          m_axis_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compares each accepted result with the oldest expected drive.
  always @(posedge clk) begin : drive_check
    drive_t got;
    drive_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = make_drive(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[16:9],
                       m_axis_tdata[17], m_axis_tdata[25:18], m_axis_tdata[33:26],
                       m_axis_tdata[41:34], m_axis_tdata[42]);
      if (pending_drives.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t ns: result expected none, actual kind %0d", $time, got.kind);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        check_field("result_kind", want.kind, got.kind);
        check_field("right_duty", want.right_duty, got.right_duty);
        check_field("right_reverse", want.right_rev, got.right_rev);
        check_field("left_duty", want.left_duty, got.left_duty);
        check_field("left_reverse", want.left_rev, got.left_rev);
        check_field("blade_duty", want.blade, got.blade);
        check_field("lift_raise_duty", want.raise_duty, got.raise_duty);
        check_field("lift_lower_duty", want.lower_duty, got.lower_duty);
        check_field("stepper_enable", want.stepper_en, got.stepper_en);
      end
    end
  end

  // Stimulus: directed rows at reset settings, then random phases under new settings.
  initial begin : stimulus
    int p;
    int k;
    int sent;
    int pick;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    // Emergency straight after reset keeps both direction pins low.
    add_row(rfdm_pkg::KIND_EMERGENCY, 8'h00, 1'b1,
            make_drive(rfdm_pkg::KIND_EMERGENCY, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0,
                       1'b0));
    // A stray byte while hunting is dropped.
    add_row(rfdm_pkg::KIND_FRAME, 8'h55, 1'b0, NO_DRIVE);
    // Empty frame: zero powers count as reverse.
    add_row(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h00, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h00, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h00, 1'b1,
            make_drive(rfdm_pkg::KIND_FRAME, 8'd0, 1'b1, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0));
    // Up by one default step, full blade.
    add_row(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h80, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h00, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'hFF, 1'b1,
            make_drive(rfdm_pkg::KIND_FRAME, 8'd5, 1'b0, 8'd5, 1'b0, 8'd255, 8'd0, 8'd0,
                       1'b0));
    // Header bytes inside the frame body are taken as data.
    add_row(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h01, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
    // Circle and square together: raise only; full left trigger.
    add_row(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h03, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'hFF, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h00, 1'b0, NO_DRIVE);
    // Cross zeroes both wheels.
    add_row(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h04, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h00, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h7F, 1'b0, NO_DRIVE);
    // Emergency in the middle of a frame drops the partial frame.
    add_row(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_FRAME, 8'h80, 1'b0, NO_DRIVE);
    add_row(rfdm_pkg::KIND_EMERGENCY, 8'hFF, 1'b0, NO_DRIVE);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (link_rows[i])
      send_link(link_rows[i].req, link_rows[i].data, link_rows[i].typed, link_rows[i].want);

    for (p = 1; p <= 8; p++) begin
      wait_idle();
      burst = 1'b0;
      calm = 1'b0;
      case (p)
        1: set_config(8'd255, 8'hFF, 8'd255);
        2: set_config(8'd0, 8'd0, 8'd0);
        3: set_config(8'd255, 8'd1, 8'd0);
        default: begin
          b0 = $urandom_range(0, 1) ? 8'($urandom_range(0, 40)) : 8'($urandom_range(0, 255));
          b1 = 8'($urandom_range(1, 64));
          b2 = 8'($urandom_range(0, 255));
          set_config(b0, b1, b2);
        end
      endcase
      // Phase 4 fills the block against a long receiver hold-off; phase 5 runs gap-free.
      if (p == 4) begin
        burst = 1'b1;
        hold_long = 1'b1;
      end
      calm = (p == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // Well-formed frame with random buttons; cross kept rare.
          b0 = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 7) != 0) b0[rfdm_pkg::BTN_CROSS] = 1'b0;
          b1 = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'd0;
          b2 = 8'($urandom_range(0, 255));
          send_link(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
          send_link(rfdm_pkg::KIND_FRAME, b0, 1'b0, NO_DRIVE);
          send_link(rfdm_pkg::KIND_FRAME, b1, 1'b0, NO_DRIVE);
          send_link(rfdm_pkg::KIND_FRAME, b2, 1'b0, NO_DRIVE);
          sent += 4;
        end else if (pick < 88) begin
          // Line noise; not counted.
          b0 = 8'($urandom_range(0, 255));
          send_link(rfdm_pkg::KIND_FRAME, b0, 1'b0, NO_DRIVE);
        end else if (pick < 94) begin
          // Frame cut short by an emergency.
          send_link(rfdm_pkg::KIND_FRAME, rfdm_pkg::FRAME_HEADER, 1'b0, NO_DRIVE);
          for (k = $urandom_range(0, 2); k > 0; k--) begin
            b0 = 8'($urandom_range(0, 255));
            send_link(rfdm_pkg::KIND_FRAME, b0, 1'b0, NO_DRIVE);
            sent++;
          end
          b0 = 8'($urandom_range(0, 255));
          send_link(rfdm_pkg::KIND_EMERGENCY, b0, 1'b0, NO_DRIVE);
          sent += 2;
        end else begin
          b0 = 8'($urandom_range(0, 255));
          send_link(rfdm_pkg::KIND_EMERGENCY, b0, 1'b0, NO_DRIVE);
          sent++;
        end
      end
    end

    burst = 1'b0;
    calm = 1'b0;
    wait_idle();
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  // Hard stop in case results never arrive.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("testbench: errors");
    $finish;
  end

endmodule
